/* design/aes128_pkg.sv */
// ----------------------------------------------------------------------------
// aes128_pkg
// Shared types, constants and GF(2^8) helpers for the AES-128 encrypt block.
// ----------------------------------------------------------------------------
package aes128_pkg;

	localparam int unsigned NUM_ROUNDS   = 10;
	localparam int unsigned KEY_ROWS     = NUM_ROUNDS + 1;
	localparam int unsigned ROW_W        = $clog2(KEY_ROWS);
	localparam int unsigned SLOT_W       = 5;
	localparam int unsigned HALF_W       = 64;
	localparam int unsigned BLOCK_W      = 2 * HALF_W;
	localparam logic [SLOT_W-1:0] KEY_HALVES = SLOT_W'(2 * KEY_ROWS);

	typedef enum logic {
		REQ_LOAD_KEY = 1'b0,
		REQ_ENCRYPT  = 1'b1
	} req_type_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FINAL
	} enc_state_t;

	// Write port of the round-key store.
	typedef struct packed {
		logic              en;
		logic              lo_half;
		logic [ROW_W-1:0]  row;
		logic [HALF_W-1:0] data;
	} key_wr_t;

	// Read port of the round-key store.
	typedef struct packed {
		logic             en;
		logic [ROW_W-1:0] row;
	} key_rd_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	// Multiply by x in GF(2^8) with the AES polynomial.
	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

endpackage

/* design/aes128_if.sv */
// ----------------------------------------------------------------------------
// aes128_req_if / aes128_rsp_if
// Valid/ready channels for requests into and ciphertext out of the block.
// ----------------------------------------------------------------------------
interface aes128_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [4:0]  key_slot;
	logic [63:0] data_hi;
	logic [63:0] data_lo;

	modport source (output valid, req_type, key_slot, data_hi, data_lo, input ready);
	modport sink   (input valid, req_type, key_slot, data_hi, data_lo, output ready);
endinterface

interface aes128_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] cipher_hi;
	logic [63:0] cipher_lo;

	modport source (output valid, cipher_hi, cipher_lo, input ready);
	modport sink   (input valid, cipher_hi, cipher_lo, output ready);
endinterface

/* design/aes128_key_store.sv */
// ----------------------------------------------------------------------------
// aes128_key_store
// Round-key memory: eleven rows of two 64-bit halves, one half written per
// load, one full 128-bit row read per cycle with registered read data.
// ----------------------------------------------------------------------------
module aes128_key_store
	import aes128_pkg::*;
(
	input  logic               clk,
	input  key_wr_t            wr,
	input  key_rd_t            rd,
	output logic [BLOCK_W-1:0] rd_key
);

	logic [HALF_W-1:0] mem_hi [KEY_ROWS];
	logic [HALF_W-1:0] mem_lo [KEY_ROWS];
	logic [HALF_W-1:0] rd_hi_q;
	logic [HALF_W-1:0] rd_lo_q;

	always_ff @(posedge clk) begin
		if (wr.en && !wr.lo_half) begin
			mem_hi[wr.row] <= wr.data;
		end
		if (wr.en && wr.lo_half) begin
			mem_lo[wr.row] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_hi_q <= mem_hi[rd.row];
			rd_lo_q <= mem_lo[rd.row];
		end
	end

	assign rd_key = {rd_hi_q, rd_lo_q};

endmodule

/* design/aes128_round.sv */
// ----------------------------------------------------------------------------
// aes128_round
// One AES round: AddRoundKey, SubBytes, ShiftRows and, unless it is the last
// round, MixColumns. Shared by all ten rounds of the sequencer.
// ----------------------------------------------------------------------------
module aes128_round
	import aes128_pkg::*;
(
	input  logic [BLOCK_W-1:0] state_in,
	input  logic [BLOCK_W-1:0] round_key,
	input  logic               last,
	output logic [BLOCK_W-1:0] state_out
);

	logic [7:0] keyed [16];
	logic [7:0] shifted [16];
	logic [7:0] mixed [16];

	always_comb begin
		// Byte 0 is the most significant byte; byte 4*c+r is column c, row r.
		for (int i = 0; i < 16; i++) begin
			keyed[i] = state_in[BLOCK_W-1-8*i -: 8] ^ round_key[BLOCK_W-1-8*i -: 8];
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				shifted[c*4+r] = SBOX[keyed[((c + r) % 4) * 4 + r]];
			end
		end
		for (int c = 0; c < 4; c++) begin
			mixed[c*4]   = xtime(shifted[c*4]) ^ xtime(shifted[c*4+1]) ^ shifted[c*4+1]
			             ^ shifted[c*4+2] ^ shifted[c*4+3];
			mixed[c*4+1] = shifted[c*4] ^ xtime(shifted[c*4+1]) ^ xtime(shifted[c*4+2])
			             ^ shifted[c*4+2] ^ shifted[c*4+3];
			mixed[c*4+2] = shifted[c*4] ^ shifted[c*4+1] ^ xtime(shifted[c*4+2])
			             ^ xtime(shifted[c*4+3]) ^ shifted[c*4+3];
			mixed[c*4+3] = xtime(shifted[c*4]) ^ shifted[c*4] ^ shifted[c*4+1]
			             ^ shifted[c*4+2] ^ xtime(shifted[c*4+3]);
		end
		for (int i = 0; i < 16; i++) begin
			state_out[BLOCK_W-1-8*i -: 8] = last ? shifted[i] : mixed[i];
		end
	end

endmodule

/* design/aes128_block_encrypt.sv */
// ----------------------------------------------------------------------------
// aes128_block_encrypt
// AES-128 block encryption over a store of eleven loaded round keys.
// ----------------------------------------------------------------------------
// A load item writes one 64-bit round-key half into the store (slots above
// 21 are dropped) and produces no result. An encrypt item runs through one
// shared round unit, one round per cycle, reading one 128-bit round key from
// the store each cycle. Round key 0 is read in the cycle that accepts the
// item. The request port then holds ready low through the ten rounds and the
// final key XOR into the output register, which makes the ciphertext item
// valid, so no new item is accepted before that. The final cycle stretches
// only while the previous ciphertext item has not yet been taken. Every
// round key used by an encrypt must have been loaded since reset.
module aes128_block_encrypt
	import aes128_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	aes128_req_if.sink   req,
	aes128_rsp_if.source rsp
);

	enc_state_t         state_q, state_d;
	logic [ROW_W-1:0]   round_q;
	logic [BLOCK_W-1:0] block_q;
	logic [BLOCK_W-1:0] round_key;
	logic [BLOCK_W-1:0] round_out;
	logic               out_valid_q;
	logic [BLOCK_W-1:0] out_q;
	logic               req_fire;
	logic               enc_start;
	logic               last_round;
	logic               out_free;
	logic               finish;
	key_wr_t            key_wr;
	key_rd_t            key_rd;

	assign req_fire   = req.valid && req.ready;
	assign enc_start  = req_fire && (req.req_type == REQ_ENCRYPT);
	assign last_round = (round_q == ROW_W'(NUM_ROUNDS - 1));
	assign out_free   = !out_valid_q || rsp.ready;

	always_comb begin
		key_wr.en      = req_fire && (req.req_type == REQ_LOAD_KEY) && (req.key_slot < KEY_HALVES);
		key_wr.lo_half = req.key_slot[0];
		key_wr.row     = req.key_slot[SLOT_W-1:1];
		key_wr.data    = req.data_hi;
	end

	aes128_key_store u_key_store (
		.clk    (clk),
		.wr     (key_wr),
		.rd     (key_rd),
		.rd_key (round_key)
	);

	aes128_round u_round (
		.state_in  (block_q),
		.round_key (round_key),
		.last      (last_round),
		.state_out (round_out)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (enc_start) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (last_round) begin
					state_d = ST_FINAL;
				end
			end
			ST_FINAL: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready  = 1'b0;
		key_rd.en  = 1'b0;
		key_rd.row = '0;
		finish     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				key_rd.en = enc_start;
			end
			ST_ROUND: begin
				key_rd.en  = 1'b1;
				key_rd.row = round_q + 1'b1;
			end
			ST_FINAL: begin
				finish = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			round_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (enc_start) begin
				round_q <= '0;
			end else if (state_q == ST_ROUND) begin
				round_q <= round_q + 1'b1;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (enc_start) begin
			block_q <= {req.data_hi, req.data_lo};
		end else if (state_q == ST_ROUND) begin
			block_q <= round_out;
		end
		if (finish) begin
			out_q <= block_q ^ round_key;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.cipher_hi = out_q[BLOCK_W-1:HALF_W];
	assign rsp.cipher_lo = out_q[HALF_W-1:0];

endmodule
